@@ design/rc4_stream_cipher_top_assert.svh @@
// Assertion macros for the RC4 stream cipher checker.
// Used by rc4_checker.sv; expects clk_i and rst_ni in scope.
`ifndef RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_STREAM_CIPHER_TOP_ASSERT_SVH

// antecedent holds -> consequent holds in the next cycle
`define RC4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rc4 assertion failed");

// antecedent holds -> consequent holds in the same cycle
`define RC4_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rc4 assertion failed");

`endif

@@ design/rc4_pkg.sv @@
// Shared constants for the RC4 stream cipher block.
// No dependencies.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned PERM_DEPTH        = 256;
  localparam int unsigned PERM_AW           = 8;
  localparam int unsigned RC4_MAX_KEY_BYTES = 256;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

endpackage

@@ design/rc4_ram.sv @@
// Generic single-port RAM with registered read data.
// Depends on rc4_pkg for the default width.
`timescale 1ns / 1ps

module rc4_ram
  import rc4_pkg::*;
#(
  parameter int unsigned WIDTH = BYTE_W,
  parameter int unsigned DEPTH = PERM_DEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/rc4_stream_cipher_top.sv @@
// RC4 stream cipher top level: sequencer around a 256-byte permutation RAM
// and a key RAM. Depends on rc4_pkg and rc4_ram.
`timescale 1ns / 1ps

// A key byte (operation 0) is stored in the key RAM while it has room. The
// key byte marked last, and a keyed data byte marked last, start key
// scheduling: the identity permutation is loaded, then each entry is
// processed (read, accumulate, two swap writes) over the single permutation
// RAM port, during which in_ready_o is low. A keyed data byte needs five
// dependent permutation reads/writes plus the output load; a byte sent while
// no key is scheduled comes back unchanged with not_keyed_o set. The output
// register holds one result, so a new transaction is taken while a result
// waits; only a second result stalls until the first is taken.

module rc4_stream_cipher_top
  import rc4_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = RC4_MAX_KEY_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [BYTE_W-1:0] byte_in_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] byte_out_o,
  output logic              not_keyed_o
);

  localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KCW = $clog2(MAX_KEY_BYTES + 1);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_INIT   = 12'b0000_0000_0010,
    ST_KS_RD  = 12'b0000_0000_0100,
    ST_KS_ACC = 12'b0000_0000_1000,
    ST_KS_WN  = 12'b0000_0001_0000,
    ST_KS_WA  = 12'b0000_0010_0000,
    ST_GEN_J  = 12'b0000_0100_0000,
    ST_GEN_WI = 12'b0000_1000_0000,
    ST_GEN_WJ = 12'b0001_0000_0000,
    ST_GEN_RT = 12'b0010_0000_0000,
    ST_EMIT   = 12'b0100_0000_0000,
    ST_SPARE  = 12'b1000_0000_0000
  } rc4_state_e;

  rc4_state_e state_q, state_d;

  logic [PERM_AW-1:0] n_q, n_d;
  logic [BYTE_W-1:0]  acc_q, acc_d;
  logic [KAW-1:0]     kidx_q, kidx_d;
  logic [KCW-1:0]     key_count_q, key_count_d;
  logic [KCW-1:0]     kidx_inc;
  logic               keyed_q, keyed_d;
  logic [BYTE_W-1:0]  i_q, i_d, j_q, j_d;
  logic [BYTE_W-1:0]  tmp_q, tmp_d;
  logic [BYTE_W-1:0]  t_q, t_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic               pass_q, pass_d;
  logic               sched_q, sched_d;
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  byte_out_q, byte_out_d;
  logic               not_keyed_q, not_keyed_d;

  logic               p_we, p_re;
  logic [PERM_AW-1:0] p_addr;
  logic [BYTE_W-1:0]  p_wdata, p_rdata;
  logic               k_we, k_re;
  logic [KAW-1:0]     k_addr;
  logic [BYTE_W-1:0]  k_rdata;

  logic accept;
  logic out_free;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .re_i    (p_re),
    .addr_i  (p_addr),
    .wdata_i (p_wdata),
    .rdata_o (p_rdata)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .re_i    (k_re),
    .addr_i  (k_addr),
    .wdata_i (byte_in_i),
    .rdata_o (k_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign kidx_inc   = KCW'(kidx_q) + KCW'(1);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    acc_d       = acc_q;
    kidx_d      = kidx_q;
    key_count_d = key_count_q;
    keyed_d     = keyed_q;
    i_d         = i_q;
    j_d         = j_q;
    tmp_d       = tmp_q;
    t_d         = t_q;
    byte_d      = byte_q;
    pass_d      = pass_q;
    sched_d     = sched_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_out_d  = byte_out_q;
    not_keyed_d = not_keyed_q;
    p_we        = 1'b0;
    p_re        = 1'b0;
    p_addr      = n_q;
    p_wdata     = n_q;
    k_we        = 1'b0;
    k_re        = 1'b0;
    k_addr      = kidx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_KEY) begin
            if (keyed_q) begin
              keyed_d     = 1'b0;
              k_we        = 1'b1;
              k_addr      = '0;
              key_count_d = KCW'(1);
            end else if (key_count_q < KCW'(MAX_KEY_BYTES)) begin
              k_we        = 1'b1;
              k_addr      = key_count_q[KAW-1:0];
              key_count_d = key_count_q + KCW'(1);
            end
            if (last_i) begin
              n_d     = '0;
              state_d = ST_INIT;
            end
          end else if (keyed_q) begin
            i_d     = i_q + 8'd1;
            p_re    = 1'b1;
            p_addr  = i_q + 8'd1;
            byte_d  = byte_in_i;
            pass_d  = 1'b0;
            sched_d = last_i;
            state_d = ST_GEN_J;
          end else begin
            byte_d  = byte_in_i;
            pass_d  = 1'b1;
            sched_d = 1'b0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_INIT: begin
        p_we    = 1'b1;
        p_addr  = n_q;
        p_wdata = n_q;
        n_d     = n_q + 8'd1;
        if (n_q == 8'hFF) begin
          acc_d   = '0;
          kidx_d  = '0;
          state_d = ST_KS_RD;
        end
      end
      ST_KS_RD: begin
        p_re    = 1'b1;
        p_addr  = n_q;
        k_re    = 1'b1;
        k_addr  = kidx_q;
        state_d = ST_KS_ACC;
      end
      ST_KS_ACC: begin
        acc_d   = acc_q + p_rdata + k_rdata;
        tmp_d   = p_rdata;
        p_re    = 1'b1;
        p_addr  = acc_q + p_rdata + k_rdata;
        state_d = ST_KS_WN;
      end
      ST_KS_WN: begin
        p_we    = 1'b1;
        p_addr  = n_q;
        p_wdata = p_rdata;
        state_d = ST_KS_WA;
      end
      ST_KS_WA: begin
        p_we    = 1'b1;
        p_addr  = acc_q;
        p_wdata = tmp_q;
        n_d     = n_q + 8'd1;
        kidx_d  = (kidx_inc >= key_count_q) ? '0 : kidx_inc[KAW-1:0];
        if (n_q == 8'hFF) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KS_RD;
        end
      end
      ST_GEN_J: begin
        tmp_d   = p_rdata;
        j_d     = j_q + p_rdata;
        p_re    = 1'b1;
        p_addr  = j_q + p_rdata;
        state_d = ST_GEN_WI;
      end
      ST_GEN_WI: begin
        p_we    = 1'b1;
        p_addr  = i_q;
        p_wdata = p_rdata;
        t_d     = tmp_q + p_rdata;
        state_d = ST_GEN_WJ;
      end
      ST_GEN_WJ: begin
        p_we    = 1'b1;
        p_addr  = j_q;
        p_wdata = tmp_q;
        state_d = ST_GEN_RT;
      end
      ST_GEN_RT: begin
        p_re    = 1'b1;
        p_addr  = t_q;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          byte_out_d  = pass_q ? byte_q : (byte_q ^ p_rdata);
          not_keyed_d = pass_q;
          n_d         = '0;
          state_d     = sched_q ? ST_INIT : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      acc_q       <= '0;
      kidx_q      <= '0;
      key_count_q <= '0;
      keyed_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      pass_q      <= 1'b0;
      sched_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      acc_q       <= acc_d;
      kidx_q      <= kidx_d;
      key_count_q <= key_count_d;
      keyed_q     <= keyed_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pass_q      <= pass_d;
      sched_q     <= sched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q       <= tmp_d;
    t_q         <= t_d;
    byte_q      <= byte_d;
    byte_out_q  <= byte_out_d;
    not_keyed_q <= not_keyed_d;
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = byte_out_q;
  assign not_keyed_o = not_keyed_q;

endmodule

@@ design/rc4_checker.sv @@
// Port-level checker for rc4_stream_cipher_top, with its bind statement.
// Depends on rc4_pkg and rc4_stream_cipher_top_assert.svh.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_top_assert.svh"

module rc4_checker
  import rc4_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              operation_i,
  input logic              last_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] byte_out_o,
  input logic              not_keyed_o
);

  logic in_txn;
  assign in_txn = in_valid_i && in_ready_o;

  // busy after data or last key byte; ready after others; output held
  `RC4_ASSERT_NEXT(a_busy_after_data, in_txn && operation_i == OP_DATA, !in_ready_o)
  `RC4_ASSERT_NEXT(a_busy_after_key_end, in_txn && operation_i == OP_KEY && last_i, !in_ready_o)
  `RC4_ASSERT_NEXT(a_ready_after_key_byte, in_txn && operation_i == OP_KEY && !last_i, in_ready_o)
  `RC4_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(byte_out_o) && $stable(not_keyed_o))

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (.*);
